[design/cte_pkg.sv]
// ============================================================================
// cte_pkg: shared types and constants of the telemetry frame encoder
// Holds the per-sample value descriptor that travels from the front part,
// through the descriptor queue, to the byte sequencer.
// ============================================================================
`default_nettype none

package cte_pkg;

    localparam int ARG_W       = 19;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 4;
    localparam int NODE_TEXT_W = 64;
    localparam int NODE_LEN_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_NODE_TEXT   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_LENGTH = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        VS_1 = 2'd0,
        VS_2 = 2'd1,
        VS_3 = 2'd2,
        VS_5 = 2'd3
    } t_vsize;

    typedef struct packed {
        logic             neg;
        t_vsize           size;
        logic [ARG_W-1:0] arg;
    } t_value;

    typedef struct packed {
        t_value temp;
        t_value hum;
        t_value soil;
    } t_desc;

endpackage

`default_nettype wire

[design/cte_front.sv]
// ============================================================================
// cte_front: sample intake and value scaling
// Registers an accepted sample, scales each reading by ten with rounding
// half away from zero, and pushes one value descriptor into the queue.
// ============================================================================
`default_nettype none

module cte_front #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic           i_sample_valid,
    input  wire logic [15:0]    i_temperature_q,
    input  wire logic [15:0]    i_humidity_q,
    input  wire logic [15:0]    i_soil_q,
    output logic                o_push,
    input  wire logic           i_push_ready,
    output cte_pkg::t_desc      o_desc
);
    import cte_pkg::*;

    localparam logic [19:0] ROUND = 20'((2 ** FRACTION_BITS) / 2);
    // An invalid temperature reads -9990, sent as a negative head of 9989.
    localparam logic [ARG_W-1:0] INVALID_TEMP_ARG = ARG_W'(9989);

    logic        r_valid;
    logic        r_sample_valid;
    logic [15:0] r_temp;
    logic [15:0] r_hum;
    logic [15:0] r_soil;

    function automatic t_vsize size_of(input logic [ARG_W-1:0] arg);
        t_vsize s;
        if (arg < ARG_W'(24)) begin
            s = VS_1;
        end else if (arg <= ARG_W'(255)) begin
            s = VS_2;
        end else if (arg <= ARG_W'(65535)) begin
            s = VS_3;
        end else begin
            s = VS_5;
        end
        return s;
    endfunction

    function automatic t_value scale_value(input logic [15:0] raw);
        logic        neg;
        logic [15:0] mag;
        logic [19:0] prod;
        logic [19:0] rnd;
        t_value      v;
        neg  = raw[15];
        mag  = neg ? (~raw + 16'd1) : raw;
        prod = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
        rnd  = (prod + ROUND) >> FRACTION_BITS;
        v.neg  = neg && (rnd != 20'd0);
        v.arg  = v.neg ? ARG_W'(rnd - 20'd1) : ARG_W'(rnd);
        v.size = size_of(v.arg);
        return v;
    endfunction

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;

    always_comb begin
        o_desc.soil = scale_value(r_soil);
        if (r_sample_valid) begin
            o_desc.temp = scale_value(r_temp);
            o_desc.hum  = scale_value(r_hum);
        end else begin
            o_desc.temp.neg  = 1'b1;
            o_desc.temp.arg  = INVALID_TEMP_ARG;
            o_desc.temp.size = VS_3;
            o_desc.hum.neg   = 1'b1;
            o_desc.hum.arg   = '0;
            o_desc.hum.size  = VS_1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_sample_valid <= i_sample_valid;
            r_temp         <= i_temperature_q;
            r_hum          <= i_humidity_q;
            r_soil         <= i_soil_q;
        end
    end

endmodule

`default_nettype wire

[design/cte_queue.sv]
// ============================================================================
// cte_queue: descriptor queue
// A short first-in first-out queue of value descriptors that lets the
// intake and the byte sequencer stall independently.
// ============================================================================
`default_nettype none

module cte_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_push_ready,
    input  cte_pkg::t_desc      i_desc,
    output logic                o_valid,
    input  wire logic           i_pop,
    output cte_pkg::t_desc      o_desc
);
    import cte_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_desc            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid      = r_count != '0;
    assign o_desc       = r_mem[r_rd];
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
        if (w_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

`default_nettype wire

[design/cte_back.sv]
// ============================================================================
// cte_back: frame byte sequencer
// Walks the frame segments of the descriptor at the head of the queue and
// sends one byte per cycle when not stalled, through a registered output stage.
// ============================================================================
`default_nettype none

module cte_back #(
    parameter int NODE_BYTES = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_q_valid,
    input  cte_pkg::t_desc                           i_desc,
    output logic                                     o_q_pop,
    input  wire logic [cte_pkg::NODE_TEXT_W-1:0]     i_node_text,
    input  wire logic [cte_pkg::NODE_LEN_W-1:0]      i_node_length,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [7:0]                               o_byte,
    output logic                                     o_last
);
    import cte_pkg::*;

    typedef enum logic [3:0] {
        SEG_MAP,
        SEG_KT,
        SEG_VT,
        SEG_KH,
        SEG_VH,
        SEG_KS,
        SEG_VS,
        SEG_KN,
        SEG_NH,
        SEG_NT
    } t_seg;

    localparam logic [7:0] MAP_HEAD   = 8'hA4;
    localparam logic [2:0] MAJOR_UINT = 3'd0;
    localparam logic [2:0] MAJOR_NINT = 3'd1;
    localparam logic [2:0] MAJOR_TEXT = 3'd3;
    localparam logic [4:0] AI_U8      = 5'd24;
    localparam logic [4:0] AI_U16     = 5'd25;
    localparam logic [4:0] AI_U32     = 5'd26;

    // Key strings with their text heads, in the order temperature, humidity,
    // soil and node.
    localparam logic [7:0] KEY_ROM [26] = '{
        8'h65, 8'h74, 8'h5F, 8'h78, 8'h31, 8'h30,
        8'h65, 8'h68, 8'h5F, 8'h78, 8'h31, 8'h30,
        8'h68, 8'h73, 8'h6F, 8'h69, 8'h6C, 8'h5F, 8'h78, 8'h31, 8'h30,
        8'h64, 8'h6E, 8'h6F, 8'h64, 8'h65
    };

    t_seg       r_seg;
    logic [3:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic                  w_step;
    logic [NODE_LEN_W-1:0] w_len;
    logic [4:0]            w_key_base;
    logic [3:0]            w_key_end;
    logic [4:0]            w_key_addr;
    t_value                w_val;
    logic [31:0]           w_arg32;
    logic [7:0]            w_val_byte;
    logic [3:0]            w_val_end;
    logic [7:0]            w_node [8];
    logic [7:0]            w_byte;
    logic                  w_seg_end;
    logic                  w_frame_end;
    t_seg                  w_seg_next;

    assign w_len = (i_node_length > NODE_LEN_W'(NODE_BYTES)) ?
                   NODE_LEN_W'(NODE_BYTES) : i_node_length;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_node[k] = i_node_text[NODE_TEXT_W-1-8*k -: 8];
        end
    end

    always_comb begin
        unique case (r_seg)
            SEG_KH: begin
                w_key_base = 5'd6;
                w_key_end  = 4'd5;
            end
            SEG_KS: begin
                w_key_base = 5'd12;
                w_key_end  = 4'd8;
            end
            SEG_KN: begin
                w_key_base = 5'd21;
                w_key_end  = 4'd4;
            end
            default: begin
                w_key_base = 5'd0;
                w_key_end  = 4'd5;
            end
        endcase
    end

    assign w_key_addr = w_key_base + {1'b0, r_idx};

    always_comb begin
        unique case (r_seg)
            SEG_VH:  w_val = i_desc.hum;
            SEG_VS:  w_val = i_desc.soil;
            default: w_val = i_desc.temp;
        endcase
    end

    assign w_arg32 = 32'(w_val.arg);

    always_comb begin
        w_val_byte = w_arg32[7:0];
        unique case (w_val.size)
            VS_1: w_val_end = 4'd0;
            VS_2: w_val_end = 4'd1;
            VS_3: w_val_end = 4'd2;
            VS_5: w_val_end = 4'd4;
        endcase
        if (r_idx == 4'd0) begin
            w_val_byte[7:5] = w_val.neg ? MAJOR_NINT : MAJOR_UINT;
            unique case (w_val.size)
                VS_1: w_val_byte[4:0] = w_arg32[4:0];
                VS_2: w_val_byte[4:0] = AI_U8;
                VS_3: w_val_byte[4:0] = AI_U16;
                VS_5: w_val_byte[4:0] = AI_U32;
            endcase
        end else if (r_idx == w_val_end - 4'd1) begin
            w_val_byte = w_arg32[15:8];
        end else if (r_idx == w_val_end - 4'd2) begin
            w_val_byte = w_arg32[23:16];
        end else if (r_idx == w_val_end - 4'd3) begin
            w_val_byte = w_arg32[31:24];
        end
    end

    always_comb begin
        w_byte      = MAP_HEAD;
        w_seg_end   = 1'b1;
        w_frame_end = 1'b0;
        w_seg_next  = SEG_MAP;
        unique case (r_seg)
            SEG_MAP: begin
                w_seg_next = SEG_KT;
            end
            SEG_KT, SEG_KH, SEG_KS, SEG_KN: begin
                w_byte    = KEY_ROM[w_key_addr];
                w_seg_end = r_idx == w_key_end;
                unique case (r_seg)
                    SEG_KT:  w_seg_next = SEG_VT;
                    SEG_KH:  w_seg_next = SEG_VH;
                    SEG_KS:  w_seg_next = SEG_VS;
                    default: w_seg_next = SEG_NH;
                endcase
            end
            SEG_VT, SEG_VH, SEG_VS: begin
                w_byte    = w_val_byte;
                w_seg_end = r_idx == w_val_end;
                unique case (r_seg)
                    SEG_VT:  w_seg_next = SEG_KH;
                    SEG_VH:  w_seg_next = SEG_KS;
                    default: w_seg_next = SEG_KN;
                endcase
            end
            SEG_NH: begin
                w_byte      = {MAJOR_TEXT, 1'b0, w_len};
                w_frame_end = w_len == '0;
                w_seg_next  = w_frame_end ? SEG_MAP : SEG_NT;
            end
            SEG_NT: begin
                w_byte      = w_node[r_idx[2:0]];
                w_seg_end   = r_idx == w_len - NODE_LEN_W'(1);
                w_frame_end = w_seg_end;
            end
            default: begin
                w_seg_next = SEG_MAP;
            end
        endcase
    end

    assign w_step  = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop = w_step && w_frame_end;
    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= SEG_MAP;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_out_valid <= 1'b1;
                if (w_seg_end) begin
                    r_seg <= w_seg_next;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_step) begin
            r_out_byte <= w_byte;
            r_out_last <= w_frame_end;
        end
    end

    a_pop_needs_descriptor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("descriptor popped from an empty queue");

    a_frame_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_seg == SEG_MAP) && (r_idx == 4'd0))
        else $error("sequencer did not return to the map head after a frame");

    a_node_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seg == SEG_NT) |-> (r_idx < 4'(w_len)))
        else $error("node text index beyond the string length");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_frame_end) |=> (r_out_valid && r_out_last))
        else $error("final frame beat not flagged");

endmodule

`default_nettype wire

[design/cbor_telemetry_frame_encoder.sv]
// ============================================================================
// cbor_telemetry_frame_encoder: sensor sample to CBOR map byte stream
// Each accepted sample becomes a four-pair CBOR map sent one byte per beat.
// ============================================================================
// Each sample yields one frame of 28 + L + Ht + Hh + Hs bytes, where L is the
// node length (capped at NODE_BYTES) and each H is the value head size of
// 1, 2, 3 or 5 bytes; at the default parameters a frame holds 31 to 45 bytes.
// The byte sequencer sends one byte per cycle while the output is not stalled
// and a sample is queued, and queued frames follow each other without gaps.
// The intake registers and scales the next sample while the current frame
// streams, and a two-entry descriptor queue holds samples waiting their turn.
// Between the acceptance of a sample and the first byte of its frame lie the
// intake register, the descriptor queue and the output register. Configuration
// writes are taken at any time and must only happen while the block is idle.
`default_nettype none

module cbor_telemetry_frame_encoder #(
    parameter int NODE_BYTES    = 8,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // temperature_q [15:0], humidity_q [31:16], soil_q [47:32]
    input  wire logic [47:0]                         s_axis_tdata,
    // sample_valid [0]
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // frame_byte [7:0]
    output logic [7:0]                               m_axis_tdata,
    output logic                                     m_axis_tlast,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [cte_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [cte_pkg::NODE_TEXT_W-1:0]     i_cfg_data
);
    import cte_pkg::*;

    logic [NODE_TEXT_W-1:0] r_node_text;
    logic [NODE_LEN_W-1:0]  r_node_length;

    logic  w_push;
    logic  w_push_ready;
    t_desc w_push_desc;
    logic  w_q_valid;
    logic  w_q_pop;
    t_desc w_q_desc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_text   <= '0;
            r_node_length <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_NODE_TEXT) begin
                r_node_text <= i_cfg_data;
            end else if (i_cfg_index == REG_NODE_LENGTH) begin
                r_node_length <= i_cfg_data[NODE_LEN_W-1:0];
            end
        end
    end

    cte_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_sample_valid  (s_axis_tuser),
        .i_temperature_q (s_axis_tdata[15:0]),
        .i_humidity_q    (s_axis_tdata[31:16]),
        .i_soil_q        (s_axis_tdata[47:32]),
        .o_push          (w_push),
        .i_push_ready    (w_push_ready),
        .o_desc          (w_push_desc)
    );

    cte_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_desc       (w_push_desc),
        .o_valid      (w_q_valid),
        .i_pop        (w_q_pop),
        .o_desc       (w_q_desc)
    );

    cte_back #(
        .NODE_BYTES (NODE_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_desc        (w_q_desc),
        .o_q_pop       (w_q_pop),
        .i_node_text   (r_node_text),
        .i_node_length (r_node_length),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_byte        (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

endmodule

`default_nettype wire
